// ----- rtl/core/prqs_pkg.sv -----
package prqs_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_LEVELS  = 4;
    localparam int LVL_W       = 2;
    localparam int ID_W        = 8;
    localparam int PRIO_W      = 2;

    localparam logic [LVL_W-1:0]  LVL_IDLE     = 2'd0;
    localparam logic [PRIO_W-1:0] PRIO_INVALID = 2'd3;

    typedef enum logic {
        OP_ENQUEUE  = 1'b0,
        OP_SCHEDULE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_BADPRIO = 2'd2,
        ST_NONE    = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_SEEK,
        S_READ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             push;
        logic             pop;
        logic             use_tail;
        logic [LVL_W-1:0] level;
    } level_cmd_t;

    typedef struct packed {
        logic [NUM_LEVELS-1:0] nonempty;
        logic                  full;
    } level_info_t;

endpackage

// ----- rtl/core/prqs_if.sv -----
interface prqs_req_if;
    logic                          valid;
    logic                          ready;
    logic                          op;
    logic [prqs_pkg::ID_W-1:0]     thread_id;
    logic [prqs_pkg::PRIO_W-1:0]   priority_req;
    logic                          current_ready;

    modport source (output valid, op, thread_id, priority_req, current_ready, input ready);
    modport sink   (input valid, op, thread_id, priority_req, current_ready, output ready);
endinterface

interface prqs_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [prqs_pkg::ID_W-1:0] next_thread;
    logic                      switch_needed;

    modport source (output valid, status, next_thread, switch_needed, input ready);
    modport sink   (input valid, status, next_thread, switch_needed, output ready);
endinterface

// ----- rtl/core/prqs_ram.sv -----
module prqs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/prqs_level_ctrl.sv -----
module prqs_level_ctrl #(
    parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  prqs_pkg::level_cmd_t           cmd,
    output prqs_pkg::level_info_t          info,
    output logic [$clog2(QUEUE_DEPTH)-1:0] ptr
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    logic [PTR_W-1:0] head_reg  [prqs_pkg::NUM_LEVELS];
    logic [PTR_W-1:0] head_next [prqs_pkg::NUM_LEVELS];
    logic [PTR_W-1:0] tail_reg  [prqs_pkg::NUM_LEVELS];
    logic [PTR_W-1:0] tail_next [prqs_pkg::NUM_LEVELS];
    logic [CNT_W-1:0] count_reg [prqs_pkg::NUM_LEVELS];
    logic [CNT_W-1:0] count_next[prqs_pkg::NUM_LEVELS];

    function automatic logic [PTR_W-1:0] advance(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        for (int i = 0; i < prqs_pkg::NUM_LEVELS; i++)
        begin
            info.nonempty[i] = (count_reg[i] != '0);
        end
        info.full = (count_reg[cmd.level] == CNT_FULL);
        ptr       = cmd.use_tail ? tail_reg[cmd.level] : head_reg[cmd.level];
    end

    always_comb
    begin
        for (int i = 0; i < prqs_pkg::NUM_LEVELS; i++)
        begin
            head_next[i]  = head_reg[i];
            tail_next[i]  = tail_reg[i];
            count_next[i] = count_reg[i];
        end
        if (cmd.push)
        begin
            tail_next[cmd.level]  = advance(tail_reg[cmd.level]);
            count_next[cmd.level] = count_reg[cmd.level] + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            head_next[cmd.level]  = advance(head_reg[cmd.level]);
            count_next[cmd.level] = count_reg[cmd.level] - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < prqs_pkg::NUM_LEVELS; i++)
            begin
                head_reg[i]  <= '0;
                tail_reg[i]  <= '0;
                count_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < prqs_pkg::NUM_LEVELS; i++)
            begin
                head_reg[i]  <= head_next[i];
                tail_reg[i]  <= tail_next[i];
                count_reg[i] <= count_next[i];
            end
        end
    end

endmodule

// ----- rtl/core/priority_ready_queue_scheduler.sv -----
// Channel  Modport  Beat carries
// req      sink     op, thread_id, priority_req, current_ready
// rsp      source   status, next_thread, switch_needed
// cfg      write    cfg_wdata sets the idle thread id when cfg_we is high
//
// An enqueue beat passes through the push step; a schedule beat goes on to the
// level search with its read and, if a level holds a thread, the registered read
// data; then the result is registered.
// The block takes one beat at a time; req.ready stays low until the result is
// in the output register, which holds it while rsp.ready is low.
// Reset clears the level pointers and counts and sets the idle id to one.
module priority_ready_queue_scheduler #(
    parameter int QUEUE_DEPTH = prqs_pkg::QUEUE_DEPTH
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [prqs_pkg::ID_W-1:0] cfg_wdata,
    prqs_req_if.sink                  req,
    prqs_rsp_if.source                rsp
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int ADDR_W = prqs_pkg::LVL_W + PTR_W;
    localparam int MEM_D  = prqs_pkg::NUM_LEVELS * (2 ** PTR_W);

    prqs_pkg::state_t      state_reg, state_next;
    prqs_pkg::level_cmd_t  cmd;
    prqs_pkg::level_info_t info;
    logic [PTR_W-1:0]      ptr;

    logic                          op_reg;
    logic [prqs_pkg::ID_W-1:0]     tid_reg;
    logic [prqs_pkg::PRIO_W-1:0]   prio_reg;
    logic                          rdy_reg;
    logic [prqs_pkg::ID_W-1:0]     idle_id_reg;
    prqs_pkg::status_t             enq_st_reg, enq_st_next;
    prqs_pkg::status_t             res_st_reg, res_st_next;
    logic [prqs_pkg::ID_W-1:0]     res_next_reg, res_next_next;
    logic                          res_sw_reg, res_sw_next;
    logic                          out_valid_reg;
    prqs_pkg::status_t             out_st_reg;
    logic [prqs_pkg::ID_W-1:0]     out_next_reg;
    logic                          out_sw_reg;

    logic                          put_needed;
    logic                          put_bad;
    logic [prqs_pkg::LVL_W-1:0]    put_lvl;
    logic                          found;
    logic [prqs_pkg::LVL_W-1:0]    sel_lvl;
    logic                          out_free;
    logic                          ram_we;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_addr;
    logic [prqs_pkg::ID_W-1:0]     ram_rdata;

    assign put_needed = (op_reg == prqs_pkg::OP_ENQUEUE) || rdy_reg;
    assign put_bad    = (tid_reg != idle_id_reg) && (prio_reg == prqs_pkg::PRIO_INVALID);
    assign put_lvl    = (tid_reg == idle_id_reg) ? prqs_pkg::LVL_IDLE
                                                 : prio_reg + prqs_pkg::LVL_W'(1);
    assign out_free   = !out_valid_reg || rsp.ready;

    always_comb
    begin
        found   = 1'b0;
        sel_lvl = '0;
        for (int i = 0; i < prqs_pkg::NUM_LEVELS; i++)
        begin
            if (info.nonempty[i])
            begin
                found   = 1'b1;
                sel_lvl = prqs_pkg::LVL_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            prqs_pkg::S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = prqs_pkg::S_PUSH;
                end
            end
            prqs_pkg::S_PUSH:
            begin
                state_next = (op_reg == prqs_pkg::OP_ENQUEUE) ? prqs_pkg::S_DONE
                                                              : prqs_pkg::S_SEEK;
            end
            prqs_pkg::S_SEEK:
            begin
                state_next = found ? prqs_pkg::S_READ : prqs_pkg::S_DONE;
            end
            prqs_pkg::S_READ:
            begin
                state_next = prqs_pkg::S_DONE;
            end
            prqs_pkg::S_DONE:
            begin
                if (out_free)
                begin
                    state_next = prqs_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = prqs_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready      = 1'b0;
        cmd.push       = 1'b0;
        cmd.pop        = 1'b0;
        cmd.use_tail   = 1'b0;
        cmd.level      = sel_lvl;
        ram_we         = 1'b0;
        ram_re         = 1'b0;
        enq_st_next    = enq_st_reg;
        res_st_next    = res_st_reg;
        res_next_next  = res_next_reg;
        res_sw_next    = res_sw_reg;
        unique case (state_reg)
            prqs_pkg::S_IDLE:
            begin
                req.ready = 1'b1;
            end
            prqs_pkg::S_PUSH:
            begin
                cmd.use_tail  = 1'b1;
                cmd.level     = put_lvl;
                enq_st_next   = prqs_pkg::ST_OK;
                if (put_needed)
                begin
                    if (put_bad)
                    begin
                        enq_st_next = prqs_pkg::ST_BADPRIO;
                    end
                    else if (info.full)
                    begin
                        enq_st_next = prqs_pkg::ST_FULL;
                    end
                    else
                    begin
                        cmd.push = 1'b1;
                        ram_we   = 1'b1;
                    end
                end
                res_st_next   = enq_st_next;
                res_next_next = '0;
                res_sw_next   = 1'b0;
            end
            prqs_pkg::S_SEEK:
            begin
                cmd.pop = found;
                ram_re  = found;
                if (!found)
                begin
                    res_st_next   = (enq_st_reg != prqs_pkg::ST_OK) ? enq_st_reg
                                                                    : prqs_pkg::ST_NONE;
                    res_next_next = tid_reg;
                    res_sw_next   = 1'b0;
                end
            end
            prqs_pkg::S_READ:
            begin
                res_st_next   = enq_st_reg;
                res_next_next = ram_rdata;
                res_sw_next   = (ram_rdata != tid_reg);
            end
            prqs_pkg::S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    assign ram_addr = {cmd.level, ptr};

    prqs_level_ctrl #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_level_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .info (info),
        .ptr  (ptr)
    );

    prqs_ram #(
        .WIDTH(prqs_pkg::ID_W),
        .DEPTH(MEM_D)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_addr),
        .wdata(tid_reg),
        .re   (ram_re),
        .raddr(ram_addr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= prqs_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            idle_id_reg   <= prqs_pkg::ID_W'(1);
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                idle_id_reg <= cfg_wdata;
            end
            if (state_reg == prqs_pkg::S_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            op_reg   <= req.op;
            tid_reg  <= req.thread_id;
            prio_reg <= req.priority_req;
            rdy_reg  <= req.current_ready;
        end
        enq_st_reg   <= enq_st_next;
        res_st_reg   <= res_st_next;
        res_next_reg <= res_next_next;
        res_sw_reg   <= res_sw_next;
        if (state_reg == prqs_pkg::S_DONE && out_free)
        begin
            out_st_reg   <= res_st_reg;
            out_next_reg <= res_next_reg;
            out_sw_reg   <= res_sw_reg;
        end
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_st_reg;
    assign rsp.next_thread   = out_next_reg;
    assign rsp.switch_needed = out_sw_reg;

endmodule

// ----- rtl/core/prqs_checker.sv -----
module prqs_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      req_valid,
    input logic                      req_ready,
    input logic                      rsp_valid,
    input logic                      rsp_ready,
    input logic [1:0]                rsp_status,
    input logic [prqs_pkg::ID_W-1:0] rsp_next_thread,
    input logic                      rsp_switch_needed
);

    // A result beat stays offered until it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result beat dropped before it was taken");

    // A stalled result beat keeps its payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=>
            $stable(rsp_status) && $stable(rsp_next_thread) && $stable(rsp_switch_needed))
        else $error("stalled result payload changed");

    // The block works on one beat at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("second request taken while one is in progress");

    // With no thread ready the current thread keeps running.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_status == prqs_pkg::ST_NONE) |-> !rsp_switch_needed)
        else $error("switch reported although no thread was ready");

endmodule

bind priority_ready_queue_scheduler prqs_checker u_prqs_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_status       (rsp.status),
    .rsp_next_thread  (rsp.next_thread),
    .rsp_switch_needed(rsp.switch_needed)
);
